>>> design/dwm_pkg.sv
package dwm_pkg;

    // Default widths for the top-level parameters
    localparam int TIME_WIDTH_DEF       = 48;
    localparam int MISS_COUNT_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int COUNT_WIDTH     = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADLINE       = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH  = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALLOWED_MISSES = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BATCH_LENGTH   = 8'd3;

    // Reset values of the configuration registers
    localparam logic [63:0]            DEADLINE_RESET       = 64'd100000;
    localparam logic [COUNT_WIDTH-1:0] WINDOW_LENGTH_RESET  = 8'd20;
    localparam logic [COUNT_WIDTH-1:0] ALLOWED_MISSES_RESET = 8'd10;
    localparam logic [COUNT_WIDTH-1:0] BATCH_LENGTH_RESET   = 8'd20;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 8'hFF;

    // Window and batch controls seen by the statistics core
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] window_length;
        logic [COUNT_WIDTH-1:0] allowed_misses;
        logic [COUNT_WIDTH-1:0] batch_length;
    } ctl_t;

    // Per-request window report
    typedef struct packed {
        logic                   done;
        logic                   met;
        logic [COUNT_WIDTH-1:0] misses;
    } win_status_t;

endpackage

>>> design/dwm_cfg_regs.sv
module dwm_cfg_regs #(
    parameter int TIME_WIDTH = dwm_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [dwm_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
    input  logic [TIME_WIDTH-1:0]                wr_data,
    output logic [TIME_WIDTH-1:0]                deadline,
    output dwm_pkg::ctl_t                        ctl
);
    import dwm_pkg::*;

    logic [TIME_WIDTH-1:0] deadline_reg;
    ctl_t                  ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg           <= TIME_WIDTH'(DEADLINE_RESET);
            ctl_reg.window_length  <= WINDOW_LENGTH_RESET;
            ctl_reg.allowed_misses <= ALLOWED_MISSES_RESET;
            ctl_reg.batch_length   <= BATCH_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            // Drop writes to unknown indexes
            unique case (wr_index)
                REG_DEADLINE:       deadline_reg           <= wr_data;
                REG_WINDOW_LENGTH:  ctl_reg.window_length  <= wr_data[COUNT_WIDTH-1:0];
                REG_ALLOWED_MISSES: ctl_reg.allowed_misses <= wr_data[COUNT_WIDTH-1:0];
                REG_BATCH_LENGTH:   ctl_reg.batch_length   <= wr_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign deadline = deadline_reg;
    assign ctl      = ctl_reg;

endmodule

>>> design/dwm_core.sv
module dwm_core #(
    parameter int TIME_WIDTH       = dwm_pkg::TIME_WIDTH_DEF,
    parameter int MISS_COUNT_WIDTH = dwm_pkg::MISS_COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        active,
    input  logic [TIME_WIDTH-1:0]       release_stamp,
    input  logic [TIME_WIDTH-1:0]       start_stamp,
    input  logic [TIME_WIDTH-1:0]       end_stamp,
    input  logic [TIME_WIDTH-1:0]       deadline,
    input  dwm_pkg::ctl_t               ctl,
    output logic [TIME_WIDTH-1:0]       exec_span,
    output logic [TIME_WIDTH-1:0]       response_span,
    output logic [TIME_WIDTH-1:0]       worst_exec,
    output logic [TIME_WIDTH-1:0]       worst_response,
    output logic [TIME_WIDTH-1:0]       high_water_mark,
    output logic [MISS_COUNT_WIDTH-1:0] total_misses,
    output dwm_pkg::win_status_t        status
);
    import dwm_pkg::*;

    logic [TIME_WIDTH-1:0]       worst_exec_reg,       worst_exec_next;
    logic [TIME_WIDTH-1:0]       worst_response_reg,   worst_response_next;
    logic [TIME_WIDTH-1:0]       high_water_reg,       high_water_next;
    logic [TIME_WIDTH-1:0]       batch_max_reg,        batch_max_next;
    logic [COUNT_WIDTH-1:0]      batch_count_reg,      batch_count_next;
    logic [MISS_COUNT_WIDTH-1:0] miss_total_reg,       miss_total_next;
    logic [COUNT_WIDTH-1:0]      activation_count_reg, activation_count_next;
    logic [COUNT_WIDTH-1:0]      window_miss_reg,      window_miss_next;

    logic [TIME_WIDTH-1:0]  ex_diff;
    logic [TIME_WIDTH-1:0]  resp_diff;
    logic                   resp_gt_bm;
    logic                   resp_gt_hw;
    logic                   bm_gt_hw;
    logic [TIME_WIDTH-1:0]  bm_upd;
    logic [COUNT_WIDTH-1:0] batch_inc;
    logic                   batch_close;
    logic                   miss;
    logic [COUNT_WIDTH-1:0] wm_upd;
    logic [COUNT_WIDTH-1:0] act_inc;
    logic                   win_close;

    assign ex_diff   = end_stamp - start_stamp;
    assign resp_diff = end_stamp - release_stamp;

    // Compare in parallel so the high-water fold needs no second compare stage
    assign resp_gt_bm = resp_diff > batch_max_reg;
    assign resp_gt_hw = resp_diff > high_water_reg;
    assign bm_gt_hw   = batch_max_reg > high_water_reg;
    assign bm_upd     = resp_gt_bm ? resp_diff : batch_max_reg;

    assign batch_inc   = batch_count_reg + COUNT_WIDTH'(1);
    assign batch_close = batch_inc >= ctl.batch_length;
    assign miss        = active && (resp_diff > deadline);

    assign wm_upd    = (miss && (window_miss_reg != COUNT_MAX)) ?
                       window_miss_reg + COUNT_WIDTH'(1) : window_miss_reg;
    assign act_inc   = activation_count_reg + COUNT_WIDTH'(1);
    assign win_close = act_inc >= ctl.window_length;

    always_comb
    begin
        worst_exec_next     = worst_exec_reg;
        worst_response_next = worst_response_reg;
        high_water_next     = high_water_reg;
        batch_max_next      = batch_max_reg;
        batch_count_next    = batch_count_reg;
        miss_total_next     = miss_total_reg;

        if (active)
        begin
            if (ex_diff > worst_exec_reg)
                worst_exec_next = ex_diff;
            if (resp_diff > worst_response_reg)
                worst_response_next = resp_diff;
            if (batch_close)
            begin
                // Fold the batch maximum, including this sample, into the mark
                if (resp_gt_bm ? resp_gt_hw : bm_gt_hw)
                    high_water_next = bm_upd;
                batch_max_next   = '0;
                batch_count_next = '0;
            end
            else
            begin
                batch_max_next   = bm_upd;
                batch_count_next = batch_inc;
            end
            if (miss && (miss_total_reg != {MISS_COUNT_WIDTH{1'b1}}))
                miss_total_next = miss_total_reg + MISS_COUNT_WIDTH'(1);
        end

        if (win_close)
        begin
            activation_count_next = '0;
            window_miss_next      = '0;
        end
        else
        begin
            activation_count_next = act_inc;
            window_miss_next      = wm_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worst_exec_reg       <= '0;
            worst_response_reg   <= '0;
            high_water_reg       <= '0;
            batch_max_reg        <= '0;
            batch_count_reg      <= '0;
            miss_total_reg       <= '0;
            activation_count_reg <= '0;
            window_miss_reg      <= '0;
        end
        else if (step)
        begin
            worst_exec_reg       <= worst_exec_next;
            worst_response_reg   <= worst_response_next;
            high_water_reg       <= high_water_next;
            batch_max_reg        <= batch_max_next;
            batch_count_reg      <= batch_count_next;
            miss_total_reg       <= miss_total_next;
            activation_count_reg <= activation_count_next;
            window_miss_reg      <= window_miss_next;
        end
    end

    assign exec_span       = active ? ex_diff : '0;
    assign response_span   = active ? resp_diff : '0;
    assign worst_exec      = worst_exec_next;
    assign worst_response  = worst_response_next;
    assign high_water_mark = high_water_next;
    assign total_misses    = miss_total_next;

    always_comb
    begin
        status.done   = win_close;
        status.met    = win_close && (wm_upd <= ctl.allowed_misses);
        status.misses = win_close ? wm_upd : '0;
    end

endmodule

>>> design/deadline_window_monitor.sv
// Deadline window monitor: an (m,k)-firm deadline monitor for one periodic task.
// Each input request is one activation with an active flag and release, start and
// end timestamps; each produces exactly one result request with execution and
// response time (modulo 2^TIME_WIDTH, zero when inactive), the worst of each since
// reset, the high-water mark of completed batch maxima, a saturating miss total
// and, when the activation closes a window of window_length activations, that
// window's miss count and pass flag. The block accepts one request per clock while
// in_stall is low and presents its result from the result register: the request
// waits in the input register while a single pass of subtract, compare and count
// fills the result register, and the running statistics update at that same edge.
// A result held under out_stall leaves room for one more request in the input
// register; the request after that sees in_stall until the held result is taken.
// Configuration is written through cfg_valid/cfg_index/cfg_data (cfg_ready is
// always high); index 0 is the deadline, 1 window_length, 2 allowed_misses,
// 3 batch_length, and other indexes are dropped. Write it only while the block is
// idle. A zero window or batch length acts as a length of one.
module deadline_window_monitor #(
    parameter int TIME_WIDTH       = dwm_pkg::TIME_WIDTH_DEF,
    parameter int MISS_COUNT_WIDTH = dwm_pkg::MISS_COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TIME_WIDTH-1:0]               cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                active,
    input  logic [TIME_WIDTH-1:0]               release_stamp,
    input  logic [TIME_WIDTH-1:0]               start_stamp,
    input  logic [TIME_WIDTH-1:0]               end_stamp,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [TIME_WIDTH-1:0]               exec_span,
    output logic [TIME_WIDTH-1:0]               response_span,
    output logic [TIME_WIDTH-1:0]               worst_exec,
    output logic [TIME_WIDTH-1:0]               worst_response,
    output logic [TIME_WIDTH-1:0]               high_water_mark,
    output logic [MISS_COUNT_WIDTH-1:0]         total_misses,
    output logic                                window_done,
    output logic                                window_met,
    output logic [dwm_pkg::COUNT_WIDTH-1:0]     window_misses
);
    import dwm_pkg::*;

    logic [TIME_WIDTH-1:0] deadline;
    ctl_t                  ctl;

    // Input register
    logic                  in_valid_reg, in_valid_next;
    logic                  active_reg;
    logic [TIME_WIDTH-1:0] release_reg;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] end_reg;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic [TIME_WIDTH-1:0]       exec_reg;
    logic [TIME_WIDTH-1:0]       resp_reg;
    logic [TIME_WIDTH-1:0]       worst_exec_out_reg;
    logic [TIME_WIDTH-1:0]       worst_resp_out_reg;
    logic [TIME_WIDTH-1:0]       high_water_out_reg;
    logic [MISS_COUNT_WIDTH-1:0] total_misses_reg;
    win_status_t                 status_reg;

    // Core results for the request in the input register
    logic [TIME_WIDTH-1:0]       core_exec;
    logic [TIME_WIDTH-1:0]       core_resp;
    logic [TIME_WIDTH-1:0]       core_worst_exec;
    logic [TIME_WIDTH-1:0]       core_worst_resp;
    logic [TIME_WIDTH-1:0]       core_high_water;
    logic [MISS_COUNT_WIDTH-1:0] core_total_misses;
    win_status_t                 core_status;

    logic out_free;
    logic advance;
    logic in_accept;

    assign cfg_ready = 1'b1;

    // Result slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    dwm_cfg_regs #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .deadline (deadline),
        .ctl      (ctl)
    );

    dwm_core #(
        .TIME_WIDTH       (TIME_WIDTH),
        .MISS_COUNT_WIDTH (MISS_COUNT_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .active          (active_reg),
        .release_stamp   (release_reg),
        .start_stamp     (start_reg),
        .end_stamp       (end_reg),
        .deadline        (deadline),
        .ctl             (ctl),
        .exec_span       (core_exec),
        .response_span   (core_resp),
        .worst_exec      (core_worst_exec),
        .worst_response  (core_worst_resp),
        .high_water_mark (core_high_water),
        .total_misses    (core_total_misses),
        .status          (core_status)
    );

    always_comb
    begin
        // Hold the input register until the result slot takes it
        priority if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        // Hold a stalled result, drop one that was taken
        priority if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            active_reg  <= active;
            release_reg <= release_stamp;
            start_reg   <= start_stamp;
            end_reg     <= end_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            exec_reg           <= core_exec;
            resp_reg           <= core_resp;
            worst_exec_out_reg <= core_worst_exec;
            worst_resp_out_reg <= core_worst_resp;
            high_water_out_reg <= core_high_water;
            total_misses_reg   <= core_total_misses;
            status_reg         <= core_status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign exec_span       = exec_reg;
    assign response_span   = resp_reg;
    assign worst_exec      = worst_exec_out_reg;
    assign worst_response  = worst_resp_out_reg;
    assign high_water_mark = high_water_out_reg;
    assign total_misses    = total_misses_reg;
    assign window_done     = status_reg.done;
    assign window_met      = status_reg.met;
    assign window_misses   = status_reg.misses;

endmodule

>>> design/dwm_checker.sv
module dwm_checker #(
    parameter int TIME_WIDTH = dwm_pkg::TIME_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [TIME_WIDTH-1:0]           exec_span,
    input logic [TIME_WIDTH-1:0]           response_span,
    input logic [TIME_WIDTH-1:0]           worst_exec,
    input logic [TIME_WIDTH-1:0]           worst_response,
    input logic [TIME_WIDTH-1:0]           high_water_mark,
    input logic                            window_done,
    input logic                            window_met,
    input logic [dwm_pkg::COUNT_WIDTH-1:0] window_misses
);
    import dwm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(worst_response)
            && $stable(exec_span) && $stable(window_misses))
        else $error("stalled result changed");

    // Window report is zero unless a window closes
    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_done |-> !window_met && (window_misses == '0))
        else $error("window report without window close");

    // Worst values already include this request
    a_worst_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (worst_exec >= exec_span) && (worst_response >= response_span))
        else $error("worst value below current time");

    // Every batch maximum is a response time seen since reset
    a_high_water: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> high_water_mark <= worst_response)
        else $error("high-water mark above worst response");

endmodule

bind deadline_window_monitor dwm_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_dwm_checker (.*);

>>> dv/tb_deadline_window_monitor.sv
`timescale 1ns / 100ps

module tb_deadline_window_monitor;

    import dwm_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int MW = MISS_COUNT_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH;

    // Index outside the register map; a write to it must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 8'hFF;

    // Timeout, well above a full run at the heaviest stalling and idling
    localparam int CYCLE_LIMIT = 100_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic          active;
        logic [TW-1:0] release_stamp;
        logic [TW-1:0] start_stamp;
        logic [TW-1:0] end_stamp;
    } activation_t;

    typedef struct packed {
        logic [TW-1:0] exec_span;
        logic [TW-1:0] response_span;
        logic [TW-1:0] worst_exec;
        logic [TW-1:0] worst_response;
        logic [TW-1:0] high_water_mark;
        logic [MW-1:0] total_misses;
        logic          window_done;
        logic          window_met;
        logic [CW-1:0] window_misses;
    } activation_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [TW-1:0]              cfg_data = '0;

    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          active = 1'b0;
    logic [TW-1:0] release_stamp = '0;
    logic [TW-1:0] start_stamp = '0;
    logic [TW-1:0] end_stamp = '0;

    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [TW-1:0] exec_span;
    logic [TW-1:0] response_span;
    logic [TW-1:0] worst_exec;
    logic [TW-1:0] worst_response;
    logic [TW-1:0] high_water_mark;
    logic [MW-1:0] total_misses;
    logic          window_done;
    logic          window_met;
    logic [CW-1:0] window_misses;

    deadline_window_monitor #(
        .TIME_WIDTH       (TW),
        .MISS_COUNT_WIDTH (MW)
    ) dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Activations waiting to be offered, and reports owed by the block
    activation_t        pending_activations[$];
    activation_report_t expected_reports[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall pattern; hold_ask is bumped by the stimulus to request a long hold-off
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    // Configuration as the block should see it
    logic [TW-1:0] deadline_cfg = DEADLINE_RESET[TW-1:0];
    logic [CW-1:0] window_cfg   = WINDOW_LENGTH_RESET;
    logic [CW-1:0] allowed_cfg  = ALLOWED_MISSES_RESET;
    logic [CW-1:0] batch_cfg    = BATCH_LENGTH_RESET;

    // Running statistics, all zero out of reset
    logic [TW-1:0] peak_exec = '0;
    logic [TW-1:0] peak_response = '0;
    logic [TW-1:0] water_mark = '0;
    logic [TW-1:0] batch_peak = '0;
    logic [CW-1:0] batch_fill = '0;
    logic [MW-1:0] miss_total = '0;
    logic [CW-1:0] window_fill = '0;
    logic [CW-1:0] window_miss_count = '0;

    function automatic void apply_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                           input logic [TW-1:0] value);
        case (idx)
            REG_DEADLINE:       deadline_cfg = value;
            REG_WINDOW_LENGTH:  window_cfg = value[CW-1:0];
            REG_ALLOWED_MISSES: allowed_cfg = value[CW-1:0];
            REG_BATCH_LENGTH:   batch_cfg = value[CW-1:0];
            default: ;
        endcase
    endfunction

    // Advance the statistics by one activation and return the report it produces
    function automatic activation_report_t account_activation(input activation_t a);
        activation_report_t r;
        logic [TW-1:0]      run;
        logic [TW-1:0]      resp;
        r = '0;
        if (a.active)
        begin
            run  = a.end_stamp - a.start_stamp;
            resp = a.end_stamp - a.release_stamp;
            if (run > peak_exec)
                peak_exec = run;
            if (resp > peak_response)
                peak_response = resp;
            if (resp > batch_peak)
                batch_peak = resp;
            batch_fill = batch_fill + CW'(1);
            // A zero batch length closes on every sample, since any count is >= 0
            if (batch_fill >= batch_cfg)
            begin
                if (batch_peak > water_mark)
                    water_mark = batch_peak;
                batch_peak = '0;
                batch_fill = '0;
            end
            if (resp > deadline_cfg)
            begin
                if (miss_total != '1)
                    miss_total = miss_total + MW'(1);
                if (window_miss_count != COUNT_MAX)
                    window_miss_count = window_miss_count + CW'(1);
            end
            r.exec_span     = run;
            r.response_span = resp;
        end
        // Idle activations still count toward the window
        window_fill = window_fill + CW'(1);
        if (window_fill >= window_cfg)
        begin
            r.window_done   = 1'b1;
            r.window_misses = window_miss_count;
            r.window_met    = (window_miss_count <= allowed_cfg);
            window_fill       = '0;
            window_miss_count = '0;
        end
        r.worst_exec      = peak_exec;
        r.worst_response  = peak_response;
        r.high_water_mark = water_mark;
        r.total_misses    = miss_total;
        return r;
    endfunction

    function automatic logic [TW-1:0] random_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TW-1:0];
    endfunction

    // Draw one activation. Most are well-formed: release, start and end in order with a
    // response spread around the deadline. The rest are idle slots and malformed stamps;
    // with wild clear the malformed ones only put start after end, so the response
    // stays realistic and the worst-response tracking keeps moving.
    function automatic activation_t draw_activation(input bit wild);
        activation_t   a;
        logic [TW-1:0] spread;
        logic [TW-1:0] resp;
        logic [TW-1:0] run;
        int            pick;
        pick = $urandom_range(0, 19);
        a.active        = 1'b1;
        a.release_stamp = random_stamp();
        if (pick < 2)
        begin
            a.active      = 1'b0;
            a.start_stamp = random_stamp();
            a.end_stamp   = random_stamp();
        end
        else if (pick < 4)
        begin
            if (wild)
            begin
                a.start_stamp = random_stamp();
                a.end_stamp   = random_stamp();
            end
            else
            begin
                a.end_stamp   = a.release_stamp + TW'($urandom_range(0, 4096));
                a.start_stamp = a.end_stamp + TW'(1) + TW'($urandom_range(0, 4096));
            end
        end
        else
        begin
            spread = (deadline_cfg >> 2) + 8;
            resp   = deadline_cfg - spread + (random_stamp() % (2 * spread + 1));
            // Hit the miss boundary exactly now and then
            if (pick == 4)
                resp = deadline_cfg;
            else if (pick == 5)
                resp = deadline_cfg + TW'(1);
            run = (resp == '1) ? random_stamp() : random_stamp() % (resp + TW'(1));
            a.end_stamp   = a.release_stamp + resp;
            a.start_stamp = a.end_stamp - run;
        end
        return a;
    endfunction

    function automatic void queue_activation(input logic act, input logic [TW-1:0] rel,
                                             input logic [TW-1:0] st, input logic [TW-1:0] en);
        activation_t a;
        a.active        = act;
        a.release_stamp = rel;
        a.start_stamp   = st;
        a.end_stamp     = en;
        pending_activations.push_back(a);
    endfunction

    function automatic void check_field(input string label, input logic [TW-1:0] want,
                                        input logic [TW-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer activations from the pending queue in bursts,
    // predict each one's report at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        activation_t nxt;
        activation_t taken;
        logic        offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && !in_stall)
            begin
                taken.active        = active;
                taken.release_stamp = release_stamp;
                taken.start_stamp   = start_stamp;
                taken.end_stamp     = end_stamp;
                expected_reports.push_back(account_activation(taken));
                offer = 1'b0;
            end
            // Hold a stalled request as it is; otherwise load the next one unless in a gap
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_activations.size() != 0)
                begin
                    nxt = pending_activations.pop_front();
                    active        <= nxt.active;
                    release_stamp <= nxt.release_stamp;
                    start_stamp   <= nxt.start_stamp;
                    end_stamp     <= nxt.end_stamp;
                    offer = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // About a third of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Report monitor: check each accepted report against the oldest
    // prediction, and drive out_stall on a pattern of its own.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_reports
        activation_report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_PRINTED)
                        $display("%0t: report with no request outstanding, %s %0h",
                                 $time, "expected none, actual exec", exec_span);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("exec_span", want.exec_span, exec_span);
                    check_field("response_span", want.response_span, response_span);
                    check_field("worst_exec", want.worst_exec, worst_exec);
                    check_field("worst_response", want.worst_response, worst_response);
                    check_field("high_water_mark", want.high_water_mark, high_water_mark);
                    check_field("total_misses", TW'(want.total_misses), TW'(total_misses));
                    check_field("window_done", TW'(want.window_done), TW'(window_done));
                    check_field("window_met", TW'(want.window_met), TW'(window_met));
                    check_field("window_misses", TW'(want.window_misses), TW'(window_misses));
                end
            end

            // A long hold-off lets the block fill up and push back on the sender
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                // Switch among free-running, light and heavy stalling at random intervals
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(8, 64);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("deadline_window_monitor verification failed");
            $finish;
        end
    end

    // Write one register; the predictor takes the value at the edge the write lands
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [TW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [TW-1:0] deadline, input logic [CW-1:0] win_len,
                             input logic [CW-1:0] allowed, input logic [CW-1:0] batch_len);
        write_register(REG_DEADLINE, deadline);
        write_register(REG_WINDOW_LENGTH, TW'(win_len));
        write_register(REG_ALLOWED_MISSES, TW'(allowed));
        write_register(REG_BATCH_LENGTH, TW'(batch_len));
    endtask

    // Sample at the falling edge so every rising-edge update has settled; the block
    // is empty once nothing is queued, nothing is offered and no report is owed.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (in_valid || pending_activations.size() != 0 || expected_reports.size() != 0);
    endtask

    task automatic run_phase(input int count, input bit wild, input bit long_hold);
        @(negedge clk);
        repeat (count)
            pending_activations.push_back(draw_activation(wild));
        if (long_hold)
            hold_ask++;
        wait_for_drain();
    endtask

    initial
    begin
        int            win;
        logic [TW-1:0] resp;
        logic [TW-1:0] rel;
        logic [TW-1:0] run;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed activations under the reset configuration
        queue_activation(1'b0, '0, '0, '0);
        queue_activation(1'b1, '0, '0, '0);
        queue_activation(1'b1, '1, '1, '1);
        queue_activation(1'b0, '1, '1, '1);
        // Stamps wrap through zero; response lands exactly on the deadline, no miss
        queue_activation(1'b1, '1, '1, TW'(99_999));
        // One count past the deadline: a miss
        queue_activation(1'b1, TW'(1000), TW'(1500), TW'(101_001));
        queue_activation(1'b1, '0, TW'(20), TW'(70));
        repeat (14)
            pending_activations.push_back(draw_activation(1'b0));
        // End before start: execution time wraps to a large value
        queue_activation(1'b1, TW'(500), TW'(900), TW'(600));
        wait_for_drain();

        // Realistic settings, the sender pausing for a drain between each
        for (int p = 0; p < 4; p++)
        begin
            win = $urandom_range(1, 40);
            configure(TW'($urandom_range(0, 200_000)), CW'(win),
                      CW'($urandom_range(0, win)), CW'($urandom_range(1, 40)));
            run_phase(100, 1'b0, p == 1);
        end

        // Every activation closes a window and a batch; check index decode and data masking
        configure(TW'(5000), 8'd3, 8'd0, 8'd1);
        write_register(REG_WINDOW_LENGTH, 48'hA5C3_0000_0001);
        write_register(REG_UNMAPPED, TW'(7));
        run_phase(80, 1'b0, 1'b1);

        // Zero lengths act as one; zero deadline makes any nonzero response a miss
        configure('0, 8'd0, 8'd0, 8'd0);
        run_phase(60, 1'b0, 1'b0);

        // Fully random stamps
        win = $urandom_range(1, 40);
        configure(TW'($urandom_range(0, 200_000)), CW'(win),
                  CW'($urandom_range(0, win)), CW'($urandom_range(1, 40)));
        run_phase(80, 1'b1, 1'b1);

        // Top of every register
        configure('1, COUNT_MAX, COUNT_MAX, COUNT_MAX);
        run_phase(120, 1'b1, 1'b0);

        // Every activation misses; the window miss count climbs in a window that stays open
        configure('0, COUNT_MAX, COUNT_MAX, COUNT_MAX);
        @(negedge clk);
        repeat (40)
        begin
            rel  = random_stamp();
            resp = TW'(1 + $urandom_range(0, 1000));
            run  = random_stamp() % (resp + TW'(1));
            queue_activation(1'b1, rel, rel + resp - run, rel + resp);
        end
        hold_ask++;
        wait_for_drain();

        // Let any stray report surface before the verdict
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("deadline_window_monitor verification clean");
        else
            $display("deadline_window_monitor verification failed");
        $finish;
    end

endmodule
